@@ rtl/core/chunk_free_list_allocator_core_macros.svh @@
// Assertion macros used by the allocator checker.
`ifndef CHUNK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define CHUNK_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CFLA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfla: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define CFLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfla: next-cycle check failed");

`endif

@@ rtl/core/cfla_pkg.sv @@
// Types and constants shared by the chunk free-list allocator modules.
`timescale 1ns / 1ps

package cfla_pkg;

  localparam int unsigned REQ_W      = 2;
  localparam int unsigned IDX_IN_W   = 10;
  localparam int unsigned CNT_IN_W   = 11;
  localparam int unsigned PAYLOAD_W  = 20;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned STRIDE_W   = 21;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE    = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_FREE   = 3'd3,
    ST_NOINIT = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_STRIDE,
    BK_BUILD,
    BK_ACCESS,
    BK_RESP
  } back_state_e;

  typedef struct packed {
    req_e                req;
    logic                range_bad;
    logic [IDX_IN_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [CNT_IN_W-1:0]  chunk_count;
    logic [PAYLOAD_W-1:0] payload_size;
    logic [ADDR_W-1:0]    pool_base;
  } cfg_t;

  typedef struct packed {
    status_e             status;
    logic [IDX_IN_W-1:0] granted;
    logic [ADDR_W-1:0]   addr;
    logic [CNT_IN_W-1:0] free_count;
  } res_t;

endpackage

@@ rtl/core/cfla_front.sv @@
// Request decode and range classification ahead of the command queue.
`timescale 1ns / 1ps

module cfla_front #(
  parameter int unsigned POOL_CHUNKS = 1024
) (
  input  logic [cfla_pkg::REQ_W-1:0]    req_type_i,
  input  logic [cfla_pkg::IDX_IN_W-1:0] chunk_index_i,
  input  logic [cfla_pkg::CNT_IN_W-1:0] chunk_count_i,
  output cfla_pkg::cmd_t                cmd_o
);

  localparam int unsigned PTR_W = $clog2(POOL_CHUNKS + 1);
  localparam int unsigned CMP_W = (PTR_W > cfla_pkg::CNT_IN_W) ? PTR_W : cfla_pkg::CNT_IN_W;

  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] active_w;

  // Chunks beyond the pool limit are not in use
  assign cnt_w    = CMP_W'(chunk_count_i);
  assign active_w = (cnt_w > CMP_W'(POOL_CHUNKS)) ? CMP_W'(POOL_CHUNKS) : cnt_w;

  assign cmd_o.req       = cfla_pkg::req_e'(req_type_i);
  assign cmd_o.range_bad = (CMP_W'(chunk_index_i) >= active_w);
  assign cmd_o.idx       = chunk_index_i;

endmodule

@@ rtl/core/cfla_cmd_queue.sv @@
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module cfla_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  cfla_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output cfla_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfla_pkg::cmd_t   slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d  = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ rtl/core/cfla_back.sv @@
// Back end: free-list state, link table, stride and address, result register.
`timescale 1ns / 1ps

module cfla_back #(
  parameter int unsigned POOL_CHUNKS  = 1024,
  parameter int unsigned LINE_BYTES   = 64,
  parameter int unsigned HEADER_BYTES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfla_pkg::cfg_t cfg_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  cfla_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output cfla_pkg::res_t res_o
);

  localparam int unsigned IDX_W  = $clog2(POOL_CHUNKS);
  localparam int unsigned PTR_W  = $clog2(POOL_CHUNKS + 1);
  localparam int unsigned CMP_W  = (PTR_W > cfla_pkg::CNT_IN_W) ? PTR_W : cfla_pkg::CNT_IN_W;
  localparam int unsigned SW     = cfla_pkg::STRIDE_W;
  localparam int unsigned PROD_W = PTR_W + SW;
  localparam int unsigned XW     = SW + 1;
  localparam int unsigned MW     = XW + 1;
  localparam int unsigned PW     = XW + MW;
  localparam int unsigned RCP_SH = XW + $clog2(LINE_BYTES);
  localparam logic [63:0] RCP_MUL =
    ((64'd1 << RCP_SH) + 64'(LINE_BYTES) - 64'd1) / 64'(LINE_BYTES);
  localparam logic [PTR_W-1:0] EMPTY = PTR_W'(POOL_CHUNKS);

  typedef struct packed {
    logic             loaned;
    logic [PTR_W-1:0] next;
  } entry_t;

  cfla_pkg::back_state_e state_q, state_d;
  cfla_pkg::cmd_t        cmd_q, cmd_d;
  cfla_pkg::status_e     status_q, status_d;
  cfla_pkg::status_e     cm_status;
  cfla_pkg::res_t        res_q, res_d;
  logic                  res_valid_q, res_valid_d;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [PTR_W-1:0]  remain_q, remain_d;
  logic [PTR_W-1:0]  built_n_q, built_n_d;
  logic              built_q, built_d;
  logic [SW-1:0]     stride_q, stride_d;
  logic [XW-1:0]     quo_q, quo_d;
  logic              step_q, step_d;
  logic [IDX_W-1:0]  bld_q, bld_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  entry_t            tbl_mem [POOL_CHUNKS];
  entry_t            rd_q;
  logic              mem_re, mem_we;
  logic [IDX_W-1:0]  mem_raddr, mem_waddr;
  entry_t            mem_wdata;

  logic [CMP_W-1:0]  cnt_w, active_w, in_idx_w, q_idx_w, gnt_w, free_w;
  logic [PTR_W-1:0]  active_n, q_idx_p, bld_p1, cm_granted;
  logic [cfla_pkg::ADDR_W-1:0] cm_addr;
  logic [SW-1:0]     stride_fin;
  logic [XW-1:0]     x_w, quo_w, line_mul;
  logic [PW-1:0]     prod_rcp;
  logic              slot_free, commit, loaned;

  assign cnt_w    = CMP_W'(cfg_i.chunk_count);
  assign active_w = (cnt_w > CMP_W'(POOL_CHUNKS)) ? CMP_W'(POOL_CHUNKS) : cnt_w;
  assign active_n = active_w[PTR_W-1:0];
  assign in_idx_w = CMP_W'(cmd_i.idx);
  assign q_idx_w  = CMP_W'(cmd_q.idx);
  assign q_idx_p  = q_idx_w[PTR_W-1:0];
  assign bld_p1   = PTR_W'(bld_q) + 1'b1;

  // Align header plus payload up to whole lines: the line count by reciprocal
  // multiply is registered, then scaled back by the line size in the next cycle
  assign x_w        = XW'(HEADER_BYTES) + XW'(cfg_i.payload_size) + XW'(LINE_BYTES - 1);
  assign prod_rcp   = PW'(x_w) * PW'(RCP_MUL[MW-1:0]);
  assign quo_w      = XW'(prod_rcp >> RCP_SH);
  assign line_mul   = quo_q * XW'(LINE_BYTES);
  assign stride_fin = line_mul[SW-1:0];

  assign loaned    = (q_idx_p < built_n_q) && rd_q.loaned;
  assign slot_free = !res_valid_q || res_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    status_d   = status_q;
    head_d     = head_q;
    remain_d   = remain_q;
    built_d    = built_q;
    built_n_d  = built_n_q;
    stride_d   = stride_q;
    quo_d      = quo_q;
    step_d     = step_q;
    bld_d      = bld_q;
    prod_d     = prod_q;
    cmd_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = in_idx_w[IDX_W-1:0];
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    commit     = 1'b0;
    cm_status  = cfla_pkg::ST_OK;
    cm_granted = '0;
    cm_addr    = '0;

    case (state_q)
      cfla_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          cmd_d       = cmd_i;
          prod_d      = PROD_W'(head_q) * PROD_W'(stride_q);
          status_d    = cfla_pkg::ST_OK;
          state_d     = cfla_pkg::BK_RESP;
          case (cmd_i.req)
            cfla_pkg::REQ_INIT: begin
              if (!built_q) begin
                step_d  = 1'b0;
                state_d = cfla_pkg::BK_STRIDE;
              end
            end
            cfla_pkg::REQ_ALLOC: begin
              if (!built_q) begin
                status_d = cfla_pkg::ST_NOINIT;
              end else if (head_q >= EMPTY) begin
                status_d = cfla_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = head_q[IDX_W-1:0];
                state_d   = cfla_pkg::BK_ACCESS;
              end
            end
            cfla_pkg::REQ_FREE: begin
              if (!built_q) begin
                status_d = cfla_pkg::ST_NOINIT;
              end else if (cmd_i.range_bad) begin
                status_d = cfla_pkg::ST_RANGE;
              end else begin
                mem_re  = 1'b1;
                state_d = cfla_pkg::BK_ACCESS;
              end
            end
            default: ;
          endcase
        end
      end

      cfla_pkg::BK_STRIDE: begin
        if (!step_q) begin
          quo_d  = quo_w;
          step_d = 1'b1;
        end else begin
          step_d   = 1'b0;
          stride_d = stride_fin;
          bld_d    = '0;
          if (active_n == '0) begin
            head_d    = EMPTY;
            remain_d  = '0;
            built_d   = 1'b1;
            built_n_d = '0;
            state_d   = cfla_pkg::BK_RESP;
          end else begin
            state_d = cfla_pkg::BK_BUILD;
          end
        end
      end

      cfla_pkg::BK_BUILD: begin
        // Link each chunk to the next; the last one ends the list
        mem_we           = 1'b1;
        mem_waddr        = bld_q;
        mem_wdata.loaned = 1'b0;
        mem_wdata.next   = (bld_p1 == active_n) ? EMPTY : bld_p1;
        bld_d            = bld_q + 1'b1;
        if (bld_p1 == active_n) begin
          head_d    = '0;
          remain_d  = active_n;
          built_d   = 1'b1;
          built_n_d = active_n;
          state_d   = cfla_pkg::BK_RESP;
        end
      end

      cfla_pkg::BK_ACCESS: begin
        if (slot_free) begin
          commit  = 1'b1;
          state_d = cfla_pkg::BK_IDLE;
          if (cmd_q.req == cfla_pkg::REQ_ALLOC) begin
            mem_we           = 1'b1;
            mem_waddr        = head_q[IDX_W-1:0];
            mem_wdata.loaned = 1'b1;
            mem_wdata.next   = EMPTY;
            head_d           = rd_q.next;
            remain_d         = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
            cm_granted       = head_q;
            cm_addr          = cfg_i.pool_base + cfla_pkg::ADDR_W'(prod_q);
          end else if (!loaned) begin
            cm_status = cfla_pkg::ST_FREE;
          end else begin
            mem_we           = 1'b1;
            mem_waddr        = q_idx_w[IDX_W-1:0];
            mem_wdata.loaned = 1'b0;
            mem_wdata.next   = head_q;
            head_d           = q_idx_p;
            remain_d         = (remain_q < EMPTY) ? remain_q + 1'b1 : remain_q;
          end
        end
      end

      cfla_pkg::BK_RESP: begin
        if (slot_free) begin
          commit    = 1'b1;
          cm_status = status_q;
          state_d   = cfla_pkg::BK_IDLE;
        end
      end

      default: begin
        state_d = cfla_pkg::BK_IDLE;
      end
    endcase
  end

  assign gnt_w  = CMP_W'(cm_granted);
  assign free_w = CMP_W'(remain_d);

  always_comb begin
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (commit) begin
      res_valid_d      = 1'b1;
      res_d.status     = cm_status;
      res_d.granted    = gnt_w[cfla_pkg::IDX_IN_W-1:0];
      res_d.addr       = cm_addr;
      res_d.free_count = free_w[cfla_pkg::CNT_IN_W-1:0];
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfla_pkg::BK_IDLE;
      head_q      <= EMPTY;
      remain_q    <= '0;
      built_q     <= 1'b0;
      built_n_q   <= '0;
      stride_q    <= '0;
      step_q      <= 1'b0;
      bld_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      remain_q    <= remain_d;
      built_q     <= built_d;
      built_n_q   <= built_n_d;
      stride_q    <= stride_d;
      step_q      <= step_d;
      bld_q       <= bld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    status_q <= status_d;
    quo_q    <= quo_d;
    prod_q   <= prod_d;
    res_q    <= res_d;
  end

  // Link table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tbl_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= tbl_mem[mem_raddr];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/core/chunk_free_list_allocator_core.sv @@
// Top level of the LIFO chunk free-list allocator.
`timescale 1ns / 1ps
//
// Hands out fixed-size chunks of a pool from a LIFO free list.
// Input channel (in_valid_i/in_ready_o) carries one request item: req_type_i
// (init, allocate, free, no-op) and chunk_index_i. Output channel (out_valid_o /
// out_ready_i) returns exactly one result item per request: status, granted
// index, chunk header address and free count after the request.
// Config channel (cfg_valid_i/cfg_ready_o) writes chunk_count, payload_size and
// pool_base by index; it is always ready and must only be used while idle.
// Requests enter a two-entry queue; the back end runs one at a time.
// Allocate and free read the link table as they leave the queue, then write
// it back and commit in the access state once the result register is free.
// Decode errors and no-ops respond directly. Init aligns the stride
// (reciprocal multiply, then scale), then writes one table entry per chunk.
// Reset empties the list and clears the built flag; no clearing pass runs, as
// a fill count masks never-written table entries.
// A stalled receiver holds the result register; the queue keeps accepting
// until it fills, then in_ready_o drops.
//

module chunk_free_list_allocator_core #(
  parameter int unsigned POOL_CHUNKS  = 1024,
  parameter int unsigned LINE_BYTES   = 64,
  parameter int unsigned HEADER_BYTES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cfla_pkg::REQ_W-1:0]      req_type_i,
  input  logic [cfla_pkg::IDX_IN_W-1:0]   chunk_index_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [cfla_pkg::IDX_IN_W-1:0]   granted_index_o,
  output logic [cfla_pkg::ADDR_W-1:0]     chunk_addr_o,
  output logic [cfla_pkg::CNT_IN_W-1:0]   free_count_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cfla_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cfla_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  cfla_pkg::cfg_t cfg_q;
  cfla_pkg::cmd_t front_cmd;
  cfla_pkg::cmd_t queue_cmd;
  cfla_pkg::res_t res;
  logic           queue_valid;
  logic           queue_ready;

  // Config registers; indexes past the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chunk_count  <= cfla_pkg::CNT_IN_W'(1024);
      cfg_q.payload_size <= cfla_pkg::PAYLOAD_W'(4096);
      cfg_q.pool_base    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cfla_pkg::CFG_CHUNK_COUNT:  cfg_q.chunk_count  <= cfg_data_i[cfla_pkg::CNT_IN_W-1:0];
        cfla_pkg::CFG_PAYLOAD_SIZE: cfg_q.payload_size <= cfg_data_i[cfla_pkg::PAYLOAD_W-1:0];
        cfla_pkg::CFG_POOL_BASE:    cfg_q.pool_base    <= cfg_data_i[cfla_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Decode the item and flag out-of-range frees while config is stable
  cfla_front #(
    .POOL_CHUNKS (POOL_CHUNKS)
  ) u_front (
    .req_type_i    (req_type_i),
    .chunk_index_i (chunk_index_i),
    .chunk_count_i (cfg_q.chunk_count),
    .cmd_o         (front_cmd)
  );

  // Decouple acceptance from execution
  cfla_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_cmd_o    (queue_cmd)
  );

  // Run list operations and hold the result until taken
  cfla_back #(
    .POOL_CHUNKS  (POOL_CHUNKS),
    .LINE_BYTES   (LINE_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_ready_o (queue_ready),
    .cmd_i       (queue_cmd),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign status_o        = res.status;
  assign granted_index_o = res.granted;
  assign chunk_addr_o    = res.addr;
  assign free_count_o    = res.free_count;

endmodule

@@ rtl/core/cfla_checker.sv @@
// Port-level checks on the allocator result channel, bound to the top level.
`timescale 1ns / 1ps
`include "chunk_free_list_allocator_core_macros.svh"

module cfla_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [2:0]                    status_o,
  input logic [cfla_pkg::IDX_IN_W-1:0] granted_index_o,
  input logic [cfla_pkg::ADDR_W-1:0]   chunk_addr_o,
  input logic [cfla_pkg::CNT_IN_W-1:0] free_count_o
);

  // A refused request grants nothing
  `CFLA_ASSERT_IMPL(a_err_no_grant, out_valid_o && status_o != cfla_pkg::ST_OK, granted_index_o == '0 && chunk_addr_o == '0)

  // Only defined status codes leave the block
  `CFLA_ASSERT_IMPL(a_status_legal, out_valid_o, status_o <= cfla_pkg::ST_NOINIT)

  // An empty list means no free chunks are counted
  `CFLA_ASSERT_IMPL(a_empty_zero, out_valid_o && status_o == cfla_pkg::ST_EMPTY, free_count_o == '0)

  // A stalled result holds
  `CFLA_ASSERT_NEXT(a_stall_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(chunk_addr_o) && $stable(free_count_o))

endmodule

bind chunk_free_list_allocator_core cfla_checker u_cfla_checker (.*);

@@ tb/chunk_pool_tracker_pkg.sv @@
// Predictor and result check for the chunk free-list allocator testbench.
`timescale 1ns / 1ps

package chunk_pool_tracker_pkg;

  import cfla_pkg::*;

  localparam int unsigned POOL_SLOTS  = 1024;
  localparam int unsigned LINE_SIZE   = 64;
  localparam int unsigned HEADER_SIZE = 64;
  localparam logic [CNT_IN_W-1:0] END_OF_LIST = 11'd1024;

  typedef struct {
    status_e             status;
    logic [IDX_IN_W-1:0] granted;
    logic [ADDR_W-1:0]   addr;
    logic [CNT_IN_W-1:0] free_count;
  } grant_t;

  class chunk_pool_tracker;
    logic [CNT_IN_W-1:0]  chunk_count;
    logic [PAYLOAD_W-1:0] payload_size;
    logic [ADDR_W-1:0]    pool_base;
    logic [CNT_IN_W-1:0]  next_free [POOL_SLOTS];
    logic [CNT_IN_W-1:0]  top_free;
    logic [CNT_IN_W-1:0]  free_left;
    bit                   on_loan [POOL_SLOTS];
    bit                   built;
    logic [STRIDE_W-1:0]  stride;
    int unsigned          loaned_ids[$];
    grant_t               owed[$];
    int unsigned          errors;

    function new();
      chunk_count  = 11'd1024;
      payload_size = 20'd4096;
      pool_base    = '0;
      top_free     = END_OF_LIST;
      free_left    = '0;
      built        = 1'b0;
      stride       = '0;
      errors       = 0;
      foreach (on_loan[i]) on_loan[i] = 1'b0;
    endfunction

    function logic [CNT_IN_W-1:0] usable();
      return (chunk_count > POOL_SLOTS) ? END_OF_LIST : chunk_count;
    endfunction

    function void note_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHUNK_COUNT:  chunk_count  = data[CNT_IN_W-1:0];
        CFG_PAYLOAD_SIZE: payload_size = data[PAYLOAD_W-1:0];
        CFG_POOL_BASE:    pool_base    = data[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request to the pool and queue the result it owes.
    function void note_request(req_e req, logic [IDX_IN_W-1:0] idx);
      grant_t      g;
      int unsigned n;
      int unsigned raw;
      int unsigned i;
      int          hit[$];
      g.status  = ST_OK;
      g.granted = '0;
      g.addr    = '0;
      case (req)
        REQ_INIT: begin
          if (!built) begin
            n      = usable();
            raw    = HEADER_SIZE + payload_size;
            stride = STRIDE_W'((raw + LINE_SIZE - 1) / LINE_SIZE * LINE_SIZE);
            for (i = 0; i < n; i++) begin
              next_free[i] = (i + 1 < n) ? CNT_IN_W'(i + 1) : END_OF_LIST;
              on_loan[i]   = 1'b0;
            end
            top_free  = (n > 0) ? '0 : END_OF_LIST;
            free_left = CNT_IN_W'(n);
            built     = 1'b1;
          end
        end
        REQ_ALLOC: begin
          if (!built) begin
            g.status = ST_NOINIT;
          end else if (top_free >= POOL_SLOTS) begin
            g.status = ST_EMPTY;
          end else begin
            g.granted = top_free[IDX_IN_W-1:0];
            top_free  = next_free[g.granted];
            if (top_free > END_OF_LIST) top_free = END_OF_LIST;
            on_loan[g.granted]   = 1'b1;
            next_free[g.granted] = END_OF_LIST;
            if (free_left > 0) free_left--;
            g.addr = pool_base + ADDR_W'(g.granted) * ADDR_W'(stride);
            loaned_ids.push_back(g.granted);
          end
        end
        REQ_FREE: begin
          if (!built) begin
            g.status = ST_NOINIT;
          end else if (idx >= usable()) begin
            g.status = ST_RANGE;
          end else if (!on_loan[idx]) begin
            g.status = ST_FREE;
          end else begin
            on_loan[idx]   = 1'b0;
            next_free[idx] = top_free;
            top_free       = {1'b0, idx};
            if (free_left < POOL_SLOTS) free_left++;
            hit = loaned_ids.find_first_index(x) with (x == idx);
            if (hit.size() > 0) loaned_ids.delete(hit[0]);
          end
        end
        default: ;
      endcase
      g.free_count = free_left;
      owed.push_back(g);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 100) $display("mismatch %0s: got %0h, want %0h", what, got, want);
    endtask

    task check_result(logic [2:0] status, logic [IDX_IN_W-1:0] granted,
                      logic [ADDR_W-1:0] addr, logic [CNT_IN_W-1:0] free_count);
      grant_t want;
      if (owed.size() == 0) begin
        report("result with no request waiting", status, 0);
        return;
      end
      want = owed.pop_front();
      if (status !== want.status) report("status", status, want.status);
      if (granted !== want.granted) report("granted_index", granted, want.granted);
      if (addr !== want.addr) report("chunk_addr", addr, want.addr);
      if (free_count !== want.free_count) report("free_count", free_count, want.free_count);
    endtask
  endclass

endpackage

@@ tb/testbench.sv @@
// Top of the chunk free-list allocator testbench: clock, reset, stimulus and checks.
`timescale 1ns / 1ps

module testbench;

  import cfla_pkg::*;
  import chunk_pool_tracker_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [REQ_W-1:0]      req_type_i;
  logic [IDX_IN_W-1:0]   chunk_index_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [2:0]            status_o;
  logic [IDX_IN_W-1:0]   granted_index_o;
  logic [ADDR_W-1:0]     chunk_addr_o;
  logic [CNT_IN_W-1:0]   free_count_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  chunk_pool_tracker pool;
  bit                send_quiet = 1'b0;
  bit                take_quiet = 1'b0;

  chunk_free_list_allocator_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .chunk_index_i   (chunk_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .chunk_addr_o    (chunk_addr_o),
    .free_count_o    (free_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Draw an idle gap per item; now and then flip into a stretch with no gaps.
  function automatic int unsigned send_gap();
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    return send_quiet ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic int unsigned take_gap();
    if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
    return take_quiet ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [ADDR_W-1:0] any_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Present one request item and hold it until accepted. Valid is left high on
  // return; the next call either reloads the payload or drops valid for a gap.
  task automatic send_request(req_e req, logic [IDX_IN_W-1:0] idx);
    int unsigned gap;
    gap = send_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    chunk_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pool.note_request(req, idx);
  endtask

  // Drop valid and hold until every owed result has come back. Always wait for
  // a clock edge first so valid is never lowered and raised in one step.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pool.owed.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pool.note_write(idx, data);
  endtask

  // Write all three registers while the block is idle.
  task automatic configure(logic [CNT_IN_W-1:0] count, logic [PAYLOAD_W-1:0] payload,
                           logic [ADDR_W-1:0] base);
    drain();
    write_reg(CFG_CHUNK_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_PAYLOAD_SIZE, CFG_DATA_W'(payload));
    write_reg(CFG_POOL_BASE, base);
    cfg_valid_i <= 1'b0;
  endtask

  // Random traffic: mostly allocates or mostly frees of chunks really on loan,
  // with a thin layer of stray frees, no-ops and repeated inits.
  task automatic run_phase(logic [CNT_IN_W-1:0] count, logic [PAYLOAD_W-1:0] payload,
                           logic [ADDR_W-1:0] base, int unsigned items,
                           int unsigned alloc_pct);
    int unsigned roll;
    int unsigned k;
    configure(count, payload, base);
    for (k = 0; k < items; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        send_request(REQ_ALLOC, IDX_IN_W'($urandom));
      end else if (roll < 98) begin
        if (pool.loaned_ids.size() > 0 && $urandom_range(0, 9) != 0)
          send_request(REQ_FREE, IDX_IN_W'(
            pool.loaned_ids[$urandom_range(0, pool.loaned_ids.size() - 1)]));
        else
          send_request(REQ_FREE, IDX_IN_W'($urandom));
      end else begin
        send_request($urandom_range(0, 1) ? REQ_NOP : REQ_INIT, IDX_IN_W'($urandom));
      end
      // Pause now and then until the pipeline is empty.
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  // Result side: stall at random, then take one result item and check it.
  initial begin
    int unsigned stall;
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = take_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      pool.check_result(status_o, granted_index_o, chunk_addr_o, free_count_o);
    end
  end

  initial begin
    pool          = new();
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    req_type_i    <= REQ_NOP;
    chunk_index_i <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_CHUNK_COUNT;
    cfg_data_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Build the pool above the chunk limit with the widest stride and a base
    // at the top of the address space, so the second grant already wraps.
    configure(11'd2047, 20'hFFFFF, 48'hFFFF_FFFF_FFFF);
    send_request(REQ_ALLOC, 10'd0);       // before init
    send_request(REQ_FREE, 10'd1023);     // before init
    send_request(REQ_NOP, 10'd1023);
    send_request(REQ_INIT, 10'd0);
    send_request(REQ_INIT, 10'd1023);     // already built: no change
    send_request(REQ_ALLOC, 10'd1023);
    send_request(REQ_ALLOC, 10'd0);
    send_request(REQ_ALLOC, 10'd512);
    send_request(REQ_FREE, 10'd1);
    send_request(REQ_FREE, 10'd1);        // second free of the same chunk
    send_request(REQ_FREE, 10'd1023);     // in range but never lent
    send_request(REQ_ALLOC, 10'd0);       // takes chunk 1 back off the top
    send_request(REQ_NOP, 10'd0);

    // Shrink the usable range; the latched stride must not follow the payload.
    configure(11'd5, 20'd0, 48'd0);
    send_request(REQ_FREE, 10'd5);
    send_request(REQ_FREE, 10'd1023);
    send_request(REQ_FREE, 10'd0);
    send_request(REQ_ALLOC, 10'd0);

    // With a count of zero every free is out of range.
    configure(11'd0, 20'd4096, any_addr());
    send_request(REQ_FREE, 10'd2);
    send_request(REQ_ALLOC, 10'd0);
    send_request(REQ_INIT, 10'd0);

    // Drain the pool to empty over three phases, then refill it.
    run_phase(11'd1024, 20'd4096, 48'd0, 400, 95);
    run_phase(11'd2047, 20'd1, 48'hFFFF_FFFF_FFFF, 400, 95);
    run_phase(11'd1024, 20'hFFFFF, any_addr(), 400, 95);
    run_phase(11'd1, 20'd0, any_addr(), 150, 20);
    run_phase(11'd1024, 20'd4096, any_addr(), 350, 15);

    drain();
    repeat (40) @(posedge clk_i);
    if (pool.owed.size() != 0) pool.report("results never returned", pool.owed.size(), 0);
    if (pool.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
